>>> hw/rtl/bsm_pkg.sv
// bsm_pkg: widths, constants, register indexes and shared types of the bus mixer
// used by every module of the stereo bus mixer; depends on nothing
package bsm_pkg;

	localparam int SW    = 24;   // sample width
	localparam int GW    = 16;   // gain field width
	localparam int MW    = 16;   // master gain width
	localparam int BW    = 27;   // internal bus width, signed q4.23
	localparam int QW    = 23;   // soft clip quotient bits
	localparam int DENW  = 30;   // soft clip divisor width
	localparam int CFGW  = 32;   // configuration data width
	localparam int IDXW  = 3;    // configuration index width
	localparam int NTRK  = 4;
	localparam int NBUS  = 4;

	// soft clip unit: sign, check, square, divisor, divider steps, result
	localparam int CLIP_LAT = 4 + QW + 1;
	localparam int LAT      = 2 + CLIP_LAT + 1 + CLIP_LAT + 3;

	localparam logic [BW-1:0]   CLIP_T    = BW'(7969178);
	localparam logic [DENW-1:0] ONE_Q23   = DENW'(8388608);
	localparam logic [GW-1:0]   GAIN_ONE  = 16'd32768;
	localparam logic [22:0]     OUT_SCALE = 23'd8388607;
	localparam logic [BW-1:0]   OUT_MAX   = BW'(8388607);

	localparam logic [MW-1:0]   MASTER_RST = 16'd16384;
	localparam logic [7:0]      ROUTE_RST  = 8'd15;
	localparam logic [CFGW-1:0] GAINS_RST  = 32'h8000_8000;

	typedef enum logic [IDXW-1:0] {
		REG_MASTER = 3'd0,
		REG_ROUTE  = 3'd1,
		REG_TRK0   = 3'd2,
		REG_TRK1   = 3'd3,
		REG_TRK2   = 3'd4,
		REG_TRK3   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic vld;
		logic last;
	} ctl_t;

	function automatic logic [GW-1:0] clamp_gain(input logic [GW-1:0] g);
		return (g > GAIN_ONE) ? GAIN_ONE : g;
	endfunction

endpackage

>>> hw/rtl/bsm_mix.sv
// bsm_mix: per-track gain multiply and bus summing, two pipeline stages
// depends on bsm_pkg
module bsm_mix (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  bsm_pkg::ctl_t                            in_ctl,
	input  logic [7:0][bsm_pkg::SW-1:0]              smp,
	input  logic [7:0]                               route,
	input  logic [3:0][bsm_pkg::CFGW-1:0]            gains,
	output bsm_pkg::ctl_t                            out_ctl,
	output logic [3:0][bsm_pkg::BW-1:0]              bus
);
	import bsm_pkg::*;

	ctl_t ctl_s1, ctl_s2;
	// [bus][track]: bus 0 main l, 1 main r, 2 cue l, 3 cue r
	logic [NBUS-1:0][NTRK-1:0][SW-1:0] term_s1;
	logic [NBUS-1:0][BW-1:0]           bus_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
		end
	end

	// product floored by the arithmetic shift, disabled routes give zero
	always_ff @(posedge clk) begin
		for (int t = 0; t < NTRK; t++) begin
			for (int c = 0; c < 2; c++) begin
				for (int b = 0; b < 2; b++) begin
					logic [GW-1:0]            g;
					logic signed [SW+GW:0]    p;
					g = clamp_gain(gains[t][b*GW +: GW]);
					p = $signed(smp[2*t+c]) * $signed({1'b0, g});
					term_s1[2*b+c][t] <= route[4*b+t] ? p[SW+GW-2:GW-1] : '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NBUS; k++) begin
			bus_s2[k] <= BW'($signed(term_s1[k][0])) + BW'($signed(term_s1[k][1]))
				+ BW'($signed(term_s1[k][2])) + BW'($signed(term_s1[k][3]));
		end
	end

	assign out_ctl = ctl_s2;
	assign bus     = bus_s2;

endmodule

>>> hw/rtl/bsm_clip.sv
// bsm_clip: pipelined soft clipper with a one-bit-per-stage restoring divider
// depends on bsm_pkg
module bsm_clip (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bsm_pkg::ctl_t                 in_ctl,
	input  logic signed [bsm_pkg::BW-1:0] x,
	output bsm_pkg::ctl_t                 out_ctl,
	output logic signed [bsm_pkg::BW-1:0] y
);
	import bsm_pkg::*;

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_out_s;
	logic sgn_s1, sgn_s2, sgn_s3, hit_s2, hit_s3;
	logic [BW-1:0]   mag_s1, mag_s2, mag_s3, e_s2, e_s3;
	logic [2*BW-1:0] sq_s3;
	logic signed [BW-1:0] y_out_s;

	// divider stage k holds the state after k quotient bits
	ctl_t            ctl_d [QW+1];
	logic            sgn_d [QW+1];
	logic            hit_d [QW+1];
	logic [BW-1:0]   mag_d [QW+1];
	logic [DENW-1:0] den_d [QW+1];
	logic [DENW-1:0] rem_d [QW+1];
	logic [QW-1:0]   quo_d [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1    <= '0;
			ctl_s2    <= '0;
			ctl_s3    <= '0;
			ctl_d[0]  <= '0;
			ctl_out_s <= '0;
		end else begin
			ctl_s1    <= in_ctl;
			ctl_s2    <= ctl_s1;
			ctl_s3    <= ctl_s2;
			ctl_d[0]  <= ctl_s3;
			ctl_out_s <= ctl_d[QW];
		end
	end

	always_ff @(posedge clk) begin
		sgn_s1 <= x[BW-1];
		mag_s1 <= x[BW-1] ? BW'(-x) : BW'(x);

		sgn_s2 <= sgn_s1;
		mag_s2 <= mag_s1;
		hit_s2 <= mag_s1 > CLIP_T;
		e_s2   <= mag_s1 - CLIP_T;

		sgn_s3 <= sgn_s2;
		mag_s3 <= mag_s2;
		hit_s3 <= hit_s2;
		e_s3   <= e_s2;
		sq_s3  <= e_s2 * e_s2;

		// divisor 1 + e^2, first partial remainder is e itself
		sgn_d[0] <= sgn_s3;
		mag_d[0] <= mag_s3;
		hit_d[0] <= hit_s3;
		den_d[0] <= ONE_Q23 + sq_s3[23 +: DENW];
		rem_d[0] <= DENW'(e_s3);
		quo_d[0] <= '0;
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [DENW:0] two;
		logic          ge;
		assign two = {rem_d[k], 1'b0};
		assign ge  = two >= {1'b0, den_d[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_d[k+1] <= '0;
			end else begin
				ctl_d[k+1] <= ctl_d[k];
			end
		end

		always_ff @(posedge clk) begin
			sgn_d[k+1] <= sgn_d[k];
			hit_d[k+1] <= hit_d[k];
			mag_d[k+1] <= mag_d[k];
			den_d[k+1] <= den_d[k];
			rem_d[k+1] <= ge ? DENW'(two - {1'b0, den_d[k]}) : two[DENW-1:0];
			quo_d[k+1] <= {quo_d[k][QW-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		logic [BW-1:0] ym;
		ym = hit_d[QW] ? (CLIP_T + BW'(quo_d[QW])) : mag_d[QW];
		y_out_s <= sgn_d[QW] ? $signed(-ym) : $signed(ym);
	end

	assign out_ctl = ctl_out_s;
	assign y       = y_out_s;

endmodule

>>> hw/rtl/bsm_scale.sv
// bsm_scale: master volume multiply, floored shift by 14
// depends on bsm_pkg
module bsm_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bsm_pkg::ctl_t                 in_ctl,
	input  logic signed [bsm_pkg::BW-1:0] x,
	input  logic [bsm_pkg::MW-1:0]        master,
	output bsm_pkg::ctl_t                 out_ctl,
	output logic signed [bsm_pkg::BW-1:0] y
);
	import bsm_pkg::*;

	ctl_t ctl_s1;
	logic signed [BW+MW:0] prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= x * $signed({1'b0, master});
	end

	assign out_ctl = ctl_s1;
	assign y       = prod_s1[BW+13:14];

endmodule

>>> hw/rtl/bsm_out.sv
// bsm_out: output scaling by 8388607/2^23, truncation toward zero and saturation
// depends on bsm_pkg
module bsm_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bsm_pkg::ctl_t                 in_ctl,
	input  logic signed [bsm_pkg::BW-1:0] x,
	output bsm_pkg::ctl_t                 out_ctl,
	output logic signed [bsm_pkg::SW-1:0] y
);
	import bsm_pkg::*;

	ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic sgn_s1, sgn_s2;
	logic [BW-1:0]    mag_s1;
	logic [BW+22:0]   p_s2;
	logic signed [SW-1:0] y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic [BW-1:0] o;
		logic [SW-1:0] s;
		sgn_s1 <= x[BW-1];
		mag_s1 <= x[BW-1] ? BW'(-x) : BW'(x);
		sgn_s2 <= sgn_s1;
		p_s2   <= mag_s1 * OUT_SCALE;
		o = p_s2[BW+22:23];
		s = (o > OUT_MAX) ? OUT_MAX[SW-1:0] : o[SW-1:0];
		y_s3   <= sgn_s2 ? $signed(-s) : $signed(s);
	end

	assign out_ctl = ctl_s3;
	assign y       = y_s3;

endmodule

>>> hw/rtl/stereo_bus_mixer_soft_clip.sv
// stereo_bus_mixer_soft_clip: four stereo tracks mixed to main and cue buses
// throughput one frame per cycle, busy stays low
// the chain per bus is gain mix, soft clip, master scale, soft clip, output scale
// each soft clip holds a 23-stage divider, one quotient bit per stage
// arst_n clears all valid bits and loads register reset values; results cannot stall
module stereo_bus_mixer_soft_clip (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [bsm_pkg::SW-1:0]   track0_left,
	input  logic signed [bsm_pkg::SW-1:0]   track0_right,
	input  logic signed [bsm_pkg::SW-1:0]   track1_left,
	input  logic signed [bsm_pkg::SW-1:0]   track1_right,
	input  logic signed [bsm_pkg::SW-1:0]   track2_left,
	input  logic signed [bsm_pkg::SW-1:0]   track2_right,
	input  logic signed [bsm_pkg::SW-1:0]   track3_left,
	input  logic signed [bsm_pkg::SW-1:0]   track3_right,
	input  logic                            frame_is_last,
	input  logic                            cfg_we,
	input  logic [bsm_pkg::IDXW-1:0]        cfg_index,
	input  logic [bsm_pkg::CFGW-1:0]        cfg_data,
	output logic                            strobe,
	output logic signed [bsm_pkg::SW-1:0]   main_left,
	output logic signed [bsm_pkg::SW-1:0]   main_right,
	output logic signed [bsm_pkg::SW-1:0]   cue_left,
	output logic signed [bsm_pkg::SW-1:0]   cue_right,
	output logic                            block_done
);
	import bsm_pkg::*;

	// configuration registers
	logic [MW-1:0]             master_q;
	logic [7:0]                route_q;
	logic [3:0][CFGW-1:0]      gains_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= MASTER_RST;
			route_q  <= ROUTE_RST;
			gains_q  <= {NTRK{GAINS_RST}};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MASTER: master_q   <= cfg_data[MW-1:0];
				REG_ROUTE:  route_q    <= cfg_data[7:0];
				REG_TRK0:   gains_q[0] <= cfg_data;
				REG_TRK1:   gains_q[1] <= cfg_data;
				REG_TRK2:   gains_q[2] <= cfg_data;
				REG_TRK3:   gains_q[3] <= cfg_data;
				default: ; // unknown index, write dropped
			endcase
		end
	end

	// every stage advances each cycle, so a transaction is taken whenever start is high
	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	ctl_t in_ctl, mix_ctl;
	logic [NBUS-1:0][BW-1:0] mix_bus;
	assign in_ctl = '{vld: accept, last: frame_is_last};

	bsm_mix u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (in_ctl),
		.smp     ({track3_right, track3_left, track2_right, track2_left,
		            track1_right, track1_left, track0_right, track0_left}),
		.route   (route_q),
		.gains   (gains_q),
		.out_ctl (mix_ctl),
		.bus     (mix_bus)
	);

	// one identical chain per bus, valid bits ride along in each
	ctl_t                 fin_ctl [NBUS];
	logic signed [SW-1:0] fin_y   [NBUS];

	for (genvar b = 0; b < NBUS; b++) begin : g_bus
		ctl_t                 c1_ctl, sc_ctl, c2_ctl;
		logic signed [BW-1:0] c1_y, sc_y, c2_y;

		// first soft clip straight off the bus sum
		bsm_clip u_clip1 (
			.clk (clk), .arst_n (arst_n),
			.in_ctl (mix_ctl), .x ($signed(mix_bus[b])),
			.out_ctl (c1_ctl), .y (c1_y)
		);

		bsm_scale u_scale (
			.clk (clk), .arst_n (arst_n),
			.in_ctl (c1_ctl), .x (c1_y), .master (master_q),
			.out_ctl (sc_ctl), .y (sc_y)
		);

		// second soft clip after master volume
		bsm_clip u_clip2 (
			.clk (clk), .arst_n (arst_n),
			.in_ctl (sc_ctl), .x (sc_y),
			.out_ctl (c2_ctl), .y (c2_y)
		);

		bsm_out u_out (
			.clk (clk), .arst_n (arst_n),
			.in_ctl (c2_ctl), .x (c2_y),
			.out_ctl (fin_ctl[b]), .y (fin_y[b])
		);
	end

	// all chains carry the same control, bus 0 marks the result
	assign strobe     = fin_ctl[0].vld;
	assign block_done = fin_ctl[0].last;
	assign main_left  = fin_y[0];
	assign main_right = fin_y[1];
	assign cue_left   = fin_y[2];
	assign cue_right  = fin_y[3];

	// pipeline fill count since reset, for checks that look back over the full latency
	logic [6:0] fill_q;
	logic       filled;
	assign filled = fill_q == 7'(LAT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (!filled) begin
			fill_q <= fill_q + 7'd1;
		end
	end

	a_strobe_lat: assert property (@(posedge clk) disable iff (!arst_n)
		filled |-> (strobe == $past(accept, LAT)))
		else $error("result strobe does not follow accepted transaction");

	a_last_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(filled && strobe) |-> (block_done == $past(frame_is_last, LAT)))
		else $error("block_done out of step with frame_is_last");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (main_left != 24'sh800000 && main_right != 24'sh800000 &&
		            cue_left != 24'sh800000 && cue_right != 24'sh800000))
		else $error("output beyond saturation range");

endmodule

>>> sim/testbench.sv
// testbench for stereo_bus_mixer_soft_clip: directed and random frames through the mixer
// depends on bsm_pkg and stereo_bus_mixer_soft_clip; a scoreboard class predicts every result
`timescale 1ns / 1ps

import bsm_pkg::*;

// one input frame and one mixed result, as seen on the ports
typedef struct packed {
	logic [7:0][SW-1:0] smp;   // track0 left, track0 right, ... track3 right
	logic               last;
} frame_t;

typedef struct packed {
	logic [SW-1:0] main_l;
	logic [SW-1:0] main_r;
	logic [SW-1:0] cue_l;
	logic [SW-1:0] cue_r;
	logic          done;
} mix_t;

class mix_scoreboard;
	logic [MW-1:0]   master;
	logic [7:0]      route;
	logic [CFGW-1:0] gains [NTRK];
	mix_t            pending_mix[$];
	int              errors;

	function new();
		master = MASTER_RST;
		route  = ROUTE_RST;
		foreach (gains[t]) gains[t] = GAINS_RST;
		errors = 0;
	endfunction

	// mirror of a register write; indexes 6 and 7 do nothing
	function void write_reg(logic [IDXW-1:0] idx, logic [CFGW-1:0] data);
		case (idx)
			REG_MASTER: master = data[MW-1:0];
			REG_ROUTE:  route = data[7:0];
			REG_TRK0, REG_TRK1, REG_TRK2, REG_TRK3: gains[idx - REG_TRK0] = data;
			default: ;
		endcase
	endfunction

	function longint knee_clip(longint x);
		longint mag, e, sq;
		mag = (x < 0) ? -x : x;
		if (mag <= longint'(CLIP_T))
			return x;
		e   = mag - longint'(CLIP_T);
		sq  = (e * e) >>> 23;
		mag = longint'(CLIP_T) + (e * 64'sd8388608) / (64'sd8388608 + sq);
		return (x < 0) ? -mag : mag;
	endfunction

	function logic [SW-1:0] bus_out(longint bus);
		longint y, p, o;
		y = knee_clip(bus);
		y = knee_clip((y * longint'(master)) >>> 14);
		p = y * 64'sd8388607;
		o = (p >= 0) ? (p >>> 23) : -((-p) >>> 23);
		if (o > 64'sd8388607)
			o = 64'sd8388607;
		if (o < -64'sd8388607)
			o = -64'sd8388607;
		return o[SW-1:0];
	endfunction

	function longint gain_of(logic [GW-1:0] g);
		return (g > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(g);
	endfunction

	// an accepted frame: work out the mixed result it must produce
	function void note_frame(frame_t f);
		longint ml, mr, cl, cr, l, r, g;
		mix_t   m;
		ml = 0; mr = 0; cl = 0; cr = 0;
		for (int t = 0; t < NTRK; t++) begin
			l = longint'($signed(f.smp[2*t]));
			r = longint'($signed(f.smp[2*t+1]));
			if (route[t]) begin
				g = gain_of(gains[t][15:0]);
				ml += (l * g) >>> 15;
				mr += (r * g) >>> 15;
			end
			if (route[4+t]) begin
				g = gain_of(gains[t][31:16]);
				cl += (l * g) >>> 15;
				cr += (r * g) >>> 15;
			end
		end
		m.main_l = bus_out(ml);
		m.main_r = bus_out(mr);
		m.cue_l  = bus_out(cl);
		m.cue_r  = bus_out(cr);
		m.done   = f.last;
		pending_mix.push_back(m);
	endfunction

	function void check_mix(mix_t got);
		mix_t exp_m;
		if (pending_mix.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result %h", got);
			return;
		end
		exp_m = pending_mix.pop_front();
		if (got !== exp_m) begin
			errors++;
			if (errors <= 10)
				$display("result: expected main %h %h cue %h %h done %b, got %h %h %h %h %b",
					exp_m.main_l, exp_m.main_r, exp_m.cue_l, exp_m.cue_r, exp_m.done,
					got.main_l, got.main_r, got.cue_l, got.cue_r, got.done);
		end
	endfunction
endclass

module testbench;
	// index values the block has no register for
	localparam logic [IDXW-1:0] REG_SPARE_A = 3'd6;
	localparam logic [IDXW-1:0] REG_SPARE_B = 3'd7;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic signed [SW-1:0]   trk [8];
	logic                   frame_is_last;
	logic                   cfg_we;
	logic [IDXW-1:0]        cfg_index;
	logic [CFGW-1:0]        cfg_data;
	logic                   strobe;
	logic signed [SW-1:0]   main_left, main_right, cue_left, cue_right;
	logic                   block_done;

	mix_scoreboard sb;
	bit            no_idle;   // set during the stretch without sender gaps

	stereo_bus_mixer_soft_clip dut (
		.clk, .arst_n, .start, .busy,
		.track0_left(trk[0]), .track0_right(trk[1]),
		.track1_left(trk[2]), .track1_right(trk[3]),
		.track2_left(trk[4]), .track2_right(trk[5]),
		.track3_left(trk[6]), .track3_right(trk[7]),
		.frame_is_last, .cfg_we, .cfg_index, .cfg_data,
		.strobe, .main_left, .main_right, .cue_left, .cue_right, .block_done
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// results cannot be held off, so every strobe is a transaction
	always @(posedge clk)
		if (arst_n && strobe)
			sb.check_mix({main_left, main_right, cue_left, cue_right, block_done});

	// register write while the block is idle, mirrored into the scoreboard
	task automatic write_reg(logic [IDXW-1:0] idx, logic [CFGW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one frame transaction, with an occasional idle cycle in front of it
	task automatic send_frame(frame_t f);
		if (!no_idle && $urandom_range(0, 99) < 37) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		for (int i = 0; i < 8; i++)
			trk[i] <= f.smp[i];
		frame_is_last <= f.last;
		do @(posedge clk); while (busy);
		sb.note_frame(f);
	endtask

	// wait for every outstanding result, then cover the pipeline depth
	task automatic drain();
		start <= 1'b0;
		while (sb.pending_mix.size() != 0)
			@(posedge clk);
		repeat (LAT + 8) @(posedge clk);
	endtask

	// extremes show up often so clipping and saturation get exercised
	function automatic logic [SW-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			3: return 24'hFFFFFF;
			4: return 24'(CLIP_T) ^ 24'($urandom_range(0, 255));
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic frame_t rand_frame();
		frame_t f;
		for (int i = 0; i < 8; i++)
			f.smp[i] = pick_sample();
		f.last = ($urandom_range(0, 7) == 0);
		return f;
	endfunction

	// gain halves mostly at or below unity, sometimes above to test the clamp
	function automatic logic [GW-1:0] pick_gain();
		case ($urandom_range(0, 4))
			0: return GAIN_ONE;
			1: return 16'($urandom);
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	task automatic random_frames(int n);
		for (int i = 0; i < n; i++)
			send_frame(rand_frame());
	endtask

	task automatic random_setting();
		write_reg(REG_MASTER, CFGW'($urandom_range(0, 1) ? $urandom_range(0, 65535)
			: $urandom_range(8192, 24576)));
		write_reg(REG_ROUTE, CFGW'($urandom_range(0, 255)));
		write_reg(REG_TRK0, {pick_gain(), pick_gain()});
		write_reg(REG_TRK1, {pick_gain(), pick_gain()});
		write_reg(REG_TRK2, {pick_gain(), pick_gain()});
		write_reg(REG_TRK3, {pick_gain(), pick_gain()});
	endtask

	initial begin
		frame_t f;
		sb = new();
		no_idle = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		foreach (trk[i]) trk[i] = '0;
		frame_is_last = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at reset settings: full scale both ways, zero, one lsb, mixed signs, clip threshold
		f.smp = {8{24'h7FFFFF}}; f.last = 1'b0; send_frame(f);
		f.smp = {8{24'h800000}}; f.last = 1'b1; send_frame(f);
		f.smp = '0;              f.last = 1'b0; send_frame(f);
		f.smp = {8{24'hFFFFFF}}; f.last = 1'b1; send_frame(f);
		f.smp = {4{24'h7FFFFF, 24'h800000}}; f.last = 1'b0; send_frame(f);
		f.smp = {8{24'(CLIP_T)}}; send_frame(f);
		f.smp = {24'h7FFFFF, 24'h800000, 144'h0}; send_frame(f);
		drain();

		// gains above unity clamp, all tracks on both buses, loudest master
		write_reg(REG_MASTER, CFGW'(16'hFFFF));
		write_reg(REG_ROUTE, CFGW'(8'hFF));
		write_reg(REG_TRK0, 32'hFFFF_FFFF);
		write_reg(REG_TRK1, 32'h8001_8001);
		write_reg(REG_TRK2, 32'h8000_0000);
		write_reg(REG_TRK3, 32'h0000_8000);
		write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_B, 32'h0000_0000);
		f.smp = {8{24'h7FFFFF}}; f.last = 1'b1; send_frame(f);
		f.smp = {8{24'h800000}}; f.last = 1'b0; send_frame(f);
		f.smp = {8{24'h100000}}; send_frame(f);
		f.smp = {8{24'hF00000}}; send_frame(f);
		random_frames(6);
		drain();

		// empty buses and silent master
		write_reg(REG_ROUTE, CFGW'(8'h00));
		f.smp = {8{24'h7FFFFF}}; f.last = 1'b1; send_frame(f);
		random_frames(2);
		drain();
		write_reg(REG_ROUTE, CFGW'(8'hFF));
		write_reg(REG_MASTER, CFGW'(16'h0000));
		f.smp = {8{24'h800000}}; send_frame(f);
		random_frames(2);
		drain();

		// random settings, one stretch at full rate without sender gaps
		for (int ph = 0; ph < 8; ph++) begin
			random_setting();
			no_idle = (ph == 3);
			random_frames(60);
			drain();
		end
		no_idle = 1'b0;

		// back to unity master and cue only
		write_reg(REG_MASTER, CFGW'(MASTER_RST));
		write_reg(REG_ROUTE, CFGW'(8'hF0));
		random_frames(30);
		drain();

		if (sb.errors == 0 && sb.pending_mix.size() == 0)
			$display("stereo_bus_mixer_soft_clip: match");
		else
			$display("stereo_bus_mixer_soft_clip: mismatch");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("stereo_bus_mixer_soft_clip: mismatch");
		$finish;
	end
endmodule

>>> files.f
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_mix.sv
hw/rtl/bsm_clip.sv
hw/rtl/bsm_scale.sv
hw/rtl/bsm_out.sv
hw/rtl/stereo_bus_mixer_soft_clip.sv
sim/testbench.sv
